/* src/look_at_view_matrix_unit_defines.svh */
// assertion macros used by the checker of the view matrix unit
`ifndef LOOK_AT_VIEW_MATRIX_UNIT_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define LAVM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define LAVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lavm_pkg.sv */
`default_nettype none

package lavm_pkg;

	localparam int FIELD_W = 32;
	localparam int WIDE_W = 64;
	// fraction bits of an axis component
	localparam int FRAC_Q = 30;

	typedef logic signed [FIELD_W-1:0] fix_t;
	typedef logic [2:0][FIELD_W-1:0] trio_t;
	typedef logic [2:0][WIDE_W-1:0] wtrio_t;

	typedef struct packed {
		fix_t eye_x;
		fix_t eye_y;
		fix_t eye_z;
		fix_t aim_x;
		fix_t aim_y;
		fix_t aim_z;
		fix_t upward_x;
		fix_t upward_y;
		fix_t upward_z;
	} req_item_t;

	typedef struct packed {
		fix_t side_x;
		fix_t side_y;
		fix_t side_z;
		fix_t side_shift;
		fix_t vert_x;
		fix_t vert_y;
		fix_t vert_z;
		fix_t vert_shift;
		fix_t fwd_x;
		fix_t fwd_y;
		fix_t fwd_z;
		fix_t fwd_shift;
	} rsp_item_t;

endpackage

`default_nettype wire

/* src/lavm_if.sv */
`default_nettype none

interface lavm_req_if;
	import lavm_pkg::*;
	logic valid;
	logic ready;
	req_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lavm_rsp_if;
	import lavm_pkg::*;
	logic valid;
	logic ready;
	rsp_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/lavm_norm.sv */
`default_nettype none

module lavm_norm #(
	parameter int SIDE_W = 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_vld,
	input wire lavm_pkg::wtrio_t in_vec,
	input wire logic [SIDE_W-1:0] in_side,
	output logic out_vld,
	output lavm_pkg::trio_t out_vec,
	output logic [SIDE_W-1:0] out_side
);
	import lavm_pkg::*;

	localparam int MAG_W = WIDE_W - 1;
	localparam int HB_W = $clog2(MAG_W);
	localparam int AX_W = FRAC_Q + 1;
	localparam int SQ_W = 2 * AX_W;
	localparam int ROOT_N = AX_W + 1;
	localparam int DIV_N = FRAC_Q + 1;
	localparam int NUM_W = AX_W + FRAC_Q + 1;
	localparam int LAT = 6 + ROOT_N + 1 + DIV_N + 1;
	localparam logic [DIV_N-1:0] ONE_Q = DIV_N'(1) << FRAC_Q;

	typedef struct packed {
		logic [2:0] neg;
		logic zero;
	} sgn_t;

	typedef struct packed {
		logic [2:0][AX_W-1:0] ax;
		sgn_t sg;
	} car_t;

	logic [LAT-1:0] vld_s;
	logic [SIDE_W-1:0] side_s [LAT];

	logic [2:0][MAG_W-1:0] mag_s1, mag_s2, mag_s3;
	logic [2:0] neg_s1, neg_s2, neg_s3;
	logic [MAG_W-1:0] max_c, max_s2;
	logic [HB_W-1:0] hb_c, hb_s3;
	logic zero_s3;
	logic [2:0][AX_W-1:0] ax_c;
	car_t car_s4, car_s5, car_s6;
	logic [2:0][SQ_W-1:0] sq_s5;
	logic [WIDE_W-1:0] sum_s6;

	logic [WIDE_W-1:0] root_rem_s [ROOT_N];
	logic [WIDE_W-1:0] root_res_s [ROOT_N];
	car_t root_car_s [ROOT_N];
	logic [WIDE_W-1:0] root_rem_c [ROOT_N];
	logic [WIDE_W-1:0] root_res_c [ROOT_N];

	logic [ROOT_N-1:0] len_c;
	logic [2:0][NUM_W-1:0] dset_num_s;
	logic [ROOT_N-1:0] dset_den_s;
	sgn_t dset_sg_s;

	logic [2:0][NUM_W-1:0] div_num_s [DIV_N];
	logic [2:0][DIV_N-1:0] div_quo_s [DIV_N];
	logic [ROOT_N-1:0] div_den_s [DIV_N];
	sgn_t div_sg_s [DIV_N];
	logic [2:0][NUM_W-1:0] div_num_c [DIV_N];
	logic [2:0][DIV_N-1:0] div_quo_c [DIV_N];

	trio_t out_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int k = 1; k < LAT; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_vld = vld_s[LAT-1];
	assign out_side = side_s[LAT-1];

	always_comb begin
		max_c = mag_s1[0];
		if (mag_s1[1] > max_c) begin
			max_c = mag_s1[1];
		end
		if (mag_s1[2] > max_c) begin
			max_c = mag_s1[2];
		end
	end

	always_comb begin
		hb_c = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (max_s2[b]) begin
				hb_c = HB_W'(b);
			end
		end
	end

	// common shift puts the largest magnitude into [2^30, 2^31)
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (hb_s3 > HB_W'(FRAC_Q)) begin
				ax_c[i] = AX_W'(mag_s3[i] >> (hb_s3 - HB_W'(FRAC_Q)));
			end else begin
				ax_c[i] = AX_W'(mag_s3[i] << (HB_W'(FRAC_Q) - hb_s3));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= in_vec[i][WIDE_W-1] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
				neg_s1[i] <= in_vec[i][WIDE_W-1];
			end
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			max_s2 <= max_c;
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			hb_s3 <= hb_c;
			zero_s3 <= (max_s2 == '0);
			car_s4.ax <= ax_c;
			car_s4.sg.neg <= neg_s3;
			car_s4.sg.zero <= zero_s3;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= car_s4.ax[i] * car_s4.ax[i];
			end
			car_s5 <= car_s4;
			sum_s6 <= WIDE_W'(sq_s5[0]) + WIDE_W'(sq_s5[1]) + WIDE_W'(sq_s5[2]);
			car_s6 <= car_s5;
		end
	end

	// integer square root, one result bit per stage
	always_comb begin
		logic [WIDE_W-1:0] rem;
		logic [WIDE_W-1:0] res;
		logic [WIDE_W-1:0] bit_v;
		logic [WIDE_W-1:0] trial;
		for (int k = 0; k < ROOT_N; k++) begin
			rem = sum_s6;
			res = '0;
			if (k > 0) begin
				rem = root_rem_s[k-1];
				res = root_res_s[k-1];
			end
			bit_v = WIDE_W'(1) << (2 * (ROOT_N - 1 - k));
			trial = res + bit_v;
			if (rem >= trial) begin
				root_rem_c[k] = rem - trial;
				root_res_c[k] = (res >> 1) + bit_v;
			end else begin
				root_rem_c[k] = rem;
				root_res_c[k] = res >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ROOT_N; k++) begin
				root_rem_s[k] <= root_rem_c[k];
				root_res_s[k] <= root_res_c[k];
			end
			root_car_s[0] <= car_s6;
			for (int k = 1; k < ROOT_N; k++) begin
				root_car_s[k] <= root_car_s[k-1];
			end
		end
	end

	assign len_c = root_res_s[ROOT_N-1][ROOT_N-1:0];

	// dividend carries half the length so the quotient rounds to nearest
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dset_num_s[i] <= NUM_W'({root_car_s[ROOT_N-1].ax[i], FRAC_Q'(0)})
					+ NUM_W'(len_c >> 1);
			end
			dset_den_s <= len_c;
			dset_sg_s <= root_car_s[ROOT_N-1].sg;
		end
	end

	// restoring division, one quotient bit per stage, three lanes
	always_comb begin
		logic [NUM_W-1:0] num;
		logic [DIV_N-1:0] quo;
		logic [ROOT_N-1:0] den;
		logic [NUM_W-1:0] dsh;
		for (int j = 0; j < DIV_N; j++) begin
			for (int i = 0; i < 3; i++) begin
				num = dset_num_s[i];
				quo = '0;
				den = dset_den_s;
				if (j > 0) begin
					num = div_num_s[j-1][i];
					quo = div_quo_s[j-1][i];
					den = div_den_s[j-1];
				end
				dsh = NUM_W'(den) << (DIV_N - 1 - j);
				if (num >= dsh) begin
					div_num_c[j][i] = num - dsh;
					div_quo_c[j][i] = quo | (DIV_N'(1) << (DIV_N - 1 - j));
				end else begin
					div_num_c[j][i] = num;
					div_quo_c[j][i] = quo;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < DIV_N; j++) begin
				div_num_s[j] <= div_num_c[j];
				div_quo_s[j] <= div_quo_c[j];
			end
			div_den_s[0] <= dset_den_s;
			div_sg_s[0] <= dset_sg_s;
			for (int j = 1; j < DIV_N; j++) begin
				div_den_s[j] <= div_den_s[j-1];
				div_sg_s[j] <= div_sg_s[j-1];
			end
		end
	end

	always_comb begin
		logic [DIV_N-1:0] qcap;
		logic [FIELD_W-1:0] qmag;
		for (int i = 0; i < 3; i++) begin
			qcap = div_quo_s[DIV_N-1][i];
			if (qcap > ONE_Q) begin
				qcap = ONE_Q;
			end
			qmag = FIELD_W'(qcap);
			if (div_sg_s[DIV_N-1].zero) begin
				out_c[i] = '0;
			end else if (div_sg_s[DIV_N-1].neg[i]) begin
				out_c[i] = -qmag;
			end else begin
				out_c[i] = qmag;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_vec <= out_c;
		end
	end

endmodule

`default_nettype wire

/* src/look_at_view_matrix_unit.sv */
`default_nettype none
// channel  side  payload                                  transfer
// req      in    eye, aim, upward (nine Q16.16 words)     req.valid && req.ready
// rsp      out   side/vert/fwd axes Q2.30 + Q16.16 shifts  rsp.valid && rsp.ready
//
// one item enters per cycle unless a stall holds the pipeline
// the pipeline runs through three 71-stage normalizers in series: square root and
// divider each resolve one bit per stage
// reset clears only the valid bits; there is no clearing pass
// a stall freezes the pipeline only while the output register holds an untaken
// result and the last stage is full; bubbles are squeezed out otherwise
module look_at_view_matrix_unit (
	input wire logic clk,
	input wire logic arst_n,
	lavm_req_if.sink req,
	lavm_rsp_if.source rsp
);
	import lavm_pkg::*;

	localparam int SIDE2_W = 2 * $bits(trio_t);
	localparam int SIDE3_W = 3 * $bits(trio_t);
	localparam logic [WIDE_W-1:0] HALF_LSB = WIDE_W'(1) << (FRAC_Q - 1);

	logic en, hold;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic n1_vld, n2_vld, n3_vld;
	logic out_vld_q;
	rsp_item_t out_q, out_c;

	wtrio_t d_s1;
	trio_t eye_s1, up_s1;

	trio_t f_n1, eye_n1, up_n1;
	logic [SIDE2_W-1:0] n1_side;

	logic [5:0][WIDE_W-1:0] pa_s2;
	trio_t eye_s2, f_s2;
	wtrio_t t_s3;
	trio_t eye_s3, f_s3;

	trio_t s_n2, eye_n2, f_n2;
	logic [SIDE2_W-1:0] n2_side;

	logic [5:0][WIDE_W-1:0] pb_s4;
	trio_t eye_s4, f_s4, s_s4;
	wtrio_t t_s5;
	trio_t eye_s5, f_s5, s_s5;

	trio_t v_n3, eye_n3, f_n3, s_n3;
	logic [SIDE3_W-1:0] n3_side;
	trio_t ax_n3 [3];

	logic [2:0][WIDE_W-1:0] dp_s6 [3];
	trio_t ax_s6 [3];
	logic [WIDE_W-1:0] nsum_s7 [3];
	trio_t ax_s7 [3];

	function automatic fix_t round_shift(logic [WIDE_W-1:0] n);
		logic [WIDE_W-1:0] x;
		logic signed [WIDE_W-1:0] q;
		fix_t r;
		x = n + HALF_LSB;
		q = $signed(x) >>> FRAC_Q;
		// saturate unless the upper bits are all sign
		if (q[WIDE_W-1:FIELD_W-1] == '0 || q[WIDE_W-1:FIELD_W-1] == '1) begin
			r = q[FIELD_W-1:0];
		end else if (q[WIDE_W-1]) begin
			r = {1'b1, {(FIELD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(FIELD_W-1){1'b1}}};
		end
		return r;
	endfunction

	assign hold = out_vld_q & ~rsp.ready;
	assign en = ~(hold & v_s7);
	assign req.ready = en;
	assign rsp.valid = out_vld_q;
	assign rsp.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= n1_vld;
			v_s3 <= v_s2;
			v_s4 <= n2_vld;
			v_s5 <= v_s4;
			v_s6 <= n3_vld;
			v_s7 <= v_s6;
		end
	end

	// forward direction, eye and up go in
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= WIDE_W'(req.data.aim_x) - WIDE_W'(req.data.eye_x);
			d_s1[1] <= WIDE_W'(req.data.aim_y) - WIDE_W'(req.data.eye_y);
			d_s1[2] <= WIDE_W'(req.data.aim_z) - WIDE_W'(req.data.eye_z);
			eye_s1 <= {req.data.eye_z, req.data.eye_y, req.data.eye_x};
			up_s1 <= {req.data.upward_z, req.data.upward_y, req.data.upward_x};
		end
	end

	lavm_norm #(
		.SIDE_W(SIDE2_W)
	) u_norm_fwd (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(v_s1),
		.in_vec(d_s1),
		.in_side({eye_s1, up_s1}),
		.out_vld(n1_vld),
		.out_vec(f_n1),
		.out_side(n1_side)
	);

	assign {eye_n1, up_n1} = n1_side;

	// up x forward
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2[0] <= $signed(up_n1[1]) * $signed(f_n1[2]);
			pa_s2[1] <= $signed(up_n1[2]) * $signed(f_n1[1]);
			pa_s2[2] <= $signed(up_n1[2]) * $signed(f_n1[0]);
			pa_s2[3] <= $signed(up_n1[0]) * $signed(f_n1[2]);
			pa_s2[4] <= $signed(up_n1[0]) * $signed(f_n1[1]);
			pa_s2[5] <= $signed(up_n1[1]) * $signed(f_n1[0]);
			eye_s2 <= eye_n1;
			f_s2 <= f_n1;
			for (int k = 0; k < 3; k++) begin
				t_s3[k] <= pa_s2[2*k] - pa_s2[2*k+1];
			end
			eye_s3 <= eye_s2;
			f_s3 <= f_s2;
		end
	end

	lavm_norm #(
		.SIDE_W(SIDE2_W)
	) u_norm_side (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(v_s3),
		.in_vec(t_s3),
		.in_side({eye_s3, f_s3}),
		.out_vld(n2_vld),
		.out_vec(s_n2),
		.out_side(n2_side)
	);

	assign {eye_n2, f_n2} = n2_side;

	// forward x side
	always_ff @(posedge clk) begin
		if (en) begin
			pb_s4[0] <= $signed(f_n2[1]) * $signed(s_n2[2]);
			pb_s4[1] <= $signed(f_n2[2]) * $signed(s_n2[1]);
			pb_s4[2] <= $signed(f_n2[2]) * $signed(s_n2[0]);
			pb_s4[3] <= $signed(f_n2[0]) * $signed(s_n2[2]);
			pb_s4[4] <= $signed(f_n2[0]) * $signed(s_n2[1]);
			pb_s4[5] <= $signed(f_n2[1]) * $signed(s_n2[0]);
			eye_s4 <= eye_n2;
			f_s4 <= f_n2;
			s_s4 <= s_n2;
			for (int k = 0; k < 3; k++) begin
				t_s5[k] <= pb_s4[2*k] - pb_s4[2*k+1];
			end
			eye_s5 <= eye_s4;
			f_s5 <= f_s4;
			s_s5 <= s_s4;
		end
	end

	lavm_norm #(
		.SIDE_W(SIDE3_W)
	) u_norm_vert (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(v_s5),
		.in_vec(t_s5),
		.in_side({eye_s5, f_s5, s_s5}),
		.out_vld(n3_vld),
		.out_vec(v_n3),
		.out_side(n3_side)
	);

	assign {eye_n3, f_n3, s_n3} = n3_side;
	assign ax_n3[0] = s_n3;
	assign ax_n3[1] = v_n3;
	assign ax_n3[2] = f_n3;

	// translations: negated axis dot eye in Q.46
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					dp_s6[k][i] <= $signed(ax_n3[k][i]) * $signed(eye_n3[i]);
				end
				ax_s6[k] <= ax_n3[k];
				nsum_s7[k] <= WIDE_W'(0) - dp_s6[k][0] - dp_s6[k][1] - dp_s6[k][2];
				ax_s7[k] <= ax_s6[k];
			end
		end
	end

	always_comb begin
		out_c.side_x = ax_s7[0][0];
		out_c.side_y = ax_s7[0][1];
		out_c.side_z = ax_s7[0][2];
		out_c.side_shift = round_shift(nsum_s7[0]);
		out_c.vert_x = ax_s7[1][0];
		out_c.vert_y = ax_s7[1][1];
		out_c.vert_z = ax_s7[1][2];
		out_c.vert_shift = round_shift(nsum_s7[1]);
		out_c.fwd_x = ax_s7[2][0];
		out_c.fwd_y = ax_s7[2][1];
		out_c.fwd_z = ax_s7[2][2];
		out_c.fwd_shift = round_shift(nsum_s7[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en && v_s7) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s7) begin
			out_q <= out_c;
		end
	end

endmodule

`default_nettype wire

/* src/lavm_checker.sv */
`default_nettype none
`include "look_at_view_matrix_unit_defines.svh"

module lavm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire lavm_pkg::rsp_item_t rsp_data
);

	// a held result keeps its value
	`LAVM_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp payload moved during stall")

	// input back-pressure only comes from a stalled result
	`LAVM_ASSERT_SAME(a_req_backpressure, clk, arst_n, !req_ready, rsp_valid && !rsp_ready, "req blocked without rsp stall")

	// no forward axis leaves the whole frame zero
	`LAVM_ASSERT_SAME(a_zero_frame, clk, arst_n, rsp_valid && rsp_data.fwd_x == 0 && rsp_data.fwd_y == 0 && rsp_data.fwd_z == 0, rsp_data.side_x == 0 && rsp_data.side_y == 0 && rsp_data.side_z == 0 && rsp_data.vert_x == 0 && rsp_data.vert_y == 0 && rsp_data.vert_z == 0 && rsp_data.side_shift == 0 && rsp_data.vert_shift == 0 && rsp_data.fwd_shift == 0, "zero forward axis with nonzero frame")

	logic unused_req_valid;
	assign unused_req_valid = req_valid;

endmodule

bind look_at_view_matrix_unit lavm_checker u_lavm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data(rsp.data)
);

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
	import lavm_pkg::*;

	typedef longint vec3_t [0:2];

	logic clk;
	logic arst_n;
	bit idle_free;
	int errors;
	rsp_item_t matrix_q [$];

	lavm_req_if req ();
	lavm_rsp_if rsp ();

	look_at_view_matrix_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic vec3_t unit_of(vec3_t v);
		longint unsigned a [0:2];
		longint unsigned m;
		longint unsigned sum;
		longint unsigned len;
		longint unsigned q;
		int hb;
		vec3_t r;
		m = 0;
		sum = 0;
		hb = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = v[i] < 0 ? 64'd0 - longint'(v[i]) : v[i];
			if (a[i] > m)
				m = a[i];
		end
		if (m == 0) begin
			r[0] = 0; r[1] = 0; r[2] = 0;
			return r;
		end
		while (hb < 63 && (m >> (hb + 1)) != 0)
			hb++;
		for (int i = 0; i < 3; i++) begin
			if (hb > 30)
				a[i] = a[i] >> (hb - 30);
			else
				a[i] = a[i] << (30 - hb);
			sum += a[i] * a[i];
		end
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (a[i] * (64'd1 << FRAC_Q) + (len >> 1)) / len;
			if (q > (64'd1 << FRAC_Q))
				q = 64'd1 << FRAC_Q;
			r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return r;
	endfunction

	function automatic vec3_t cross_of(vec3_t a, vec3_t b);
		vec3_t r;
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
		return r;
	endfunction

	// rounds -(axis . eye) from Q.46 to Q16.16, ties up, saturated
	function automatic fix_t shift_of(vec3_t ax, vec3_t eye);
		longint x;
		longint q;
		x = -(ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2]) + (64'sd1 <<< 29);
		q = x >>> 30;
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return fix_t'(q);
	endfunction

	function automatic rsp_item_t view_matrix(req_item_t it);
		vec3_t eye, aim, up, d, f, s, v;
		rsp_item_t o;
		eye[0] = it.eye_x; eye[1] = it.eye_y; eye[2] = it.eye_z;
		aim[0] = it.aim_x; aim[1] = it.aim_y; aim[2] = it.aim_z;
		up[0] = it.upward_x; up[1] = it.upward_y; up[2] = it.upward_z;
		for (int i = 0; i < 3; i++)
			d[i] = aim[i] - eye[i];
		f = unit_of(d);
		s = unit_of(cross_of(up, f));
		v = unit_of(cross_of(f, s));
		o.side_x = fix_t'(s[0]); o.side_y = fix_t'(s[1]); o.side_z = fix_t'(s[2]);
		o.side_shift = shift_of(s, eye);
		o.vert_x = fix_t'(v[0]); o.vert_y = fix_t'(v[1]); o.vert_z = fix_t'(v[2]);
		o.vert_shift = shift_of(v, eye);
		o.fwd_x = fix_t'(f[0]); o.fwd_y = fix_t'(f[1]); o.fwd_z = fix_t'(f[2]);
		o.fwd_shift = shift_of(f, eye);
		return o;
	endfunction

	task automatic send_item(req_item_t it);
		int gap;
		gap = idle_free ? 0 : $urandom_range(19, 0);
		if (gap > 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.data <= it;
		do @(posedge clk); while (!req.ready);
		matrix_q.push_back(view_matrix(it));
	endtask

	// the last item was just taken, so valid drops before the next edge
	task automatic drain_results();
		@(negedge clk);
		req.valid <= 1'b0;
		while (matrix_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic req_item_t make_item(fix_t ex, fix_t ey, fix_t ez, fix_t ax, fix_t ay,
			fix_t az, fix_t ux, fix_t uy, fix_t uz);
		req_item_t it;
		it = '{ex, ey, ez, ax, ay, az, ux, uy, uz};
		return it;
	endfunction

	function automatic fix_t rand_word(int mode);
		case (mode)
			0: return fix_t'($urandom);
			1: return fix_t'($urandom_range(32'h00040000, 0)) - fix_t'(32'h00020000);
			2: return fix_t'($urandom_range(8, 0)) - 4;
			default: return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	task automatic test_extremes();
		fix_t mx, mn;
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		send_item(make_item(0, 0, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 0));
		send_item(make_item(mn, mn, mn, mx, mx, mx, mx, mn, mx));
		send_item(make_item(mx, mx, mx, mn, mn, mn, mn, mx, mn));
		send_item(make_item(mx, mn, mx, mn, mx, mn, mx, mx, mx));
		send_item(make_item(mn, 0, 0, mx, 0, 0, 0, mn, 0));
		send_item(make_item(-1, -1, -1, 1, 1, 1, -1, 1, -1));
		send_item(make_item(mx, mx, mx, mx, mx, mx - 1, 1, 0, 0));
		send_item(make_item(32'sh12345, -32'sh6789a, 32'sh40000, 0, 0, 0,
			32'sh10000, 32'sh20000, -32'sh30000));
	endtask

	task automatic test_degenerate();
		// eye on the target: forward is zero
		send_item(make_item(32'sh50000, -32'sh20000, 7, 32'sh50000, -32'sh20000, 7, 0, 1, 0));
		send_item(make_item(32'sh80000000, 32'sh7fffffff, 0, 32'sh80000000, 32'sh7fffffff, 0,
			5, 5, 5));
		// zero up vector
		send_item(make_item(1, 2, 3, 32'sh40000, 9, -32'sh30000, 0, 0, 0));
		// up parallel or antiparallel to forward
		send_item(make_item(0, 0, 0, 0, 32'sh30000, 0, 0, 32'sh10000, 0));
		send_item(make_item(32'sh10000, 32'sh10000, 32'sh10000, 32'sh30000, 32'sh30000,
			32'sh30000, -32'sh20000, -32'sh20000, -32'sh20000));
		send_item(make_item(-5, 0, 0, 32'sh7fff0000, 0, 0, 32'sh80000000, 0, 0));
		drain_results();
	endtask

	task automatic test_random(int count);
		req_item_t it;
		int mode;
		for (int n = 0; n < count; n++) begin
			if (n % 60 == 0)
				idle_free = ($urandom_range(3, 0) == 0);
			mode = $urandom_range(9, 0);
			it = make_item(rand_word(mode % 4), rand_word(mode % 4), rand_word(mode % 4),
				rand_word(mode % 3), rand_word(mode % 3), rand_word(mode % 3),
				rand_word(mode % 4), rand_word(mode % 4), rand_word(mode % 4));
			if (mode == 8) begin
				it.aim_x = it.eye_x; it.aim_y = it.eye_y; it.aim_z = it.eye_z;
			end else if (mode == 9) begin
				it.upward_x = it.aim_x - it.eye_x;
				it.upward_y = it.aim_y - it.eye_y;
				it.upward_z = it.aim_z - it.eye_z;
			end
			send_item(it);
			if (n == count / 2)
				drain_results();
		end
		idle_free = 1'b0;
	endtask

	initial begin
		int stall;
		rsp.ready <= 1'b0;
		forever begin
			stall = idle_free ? 0 : $urandom_range(19, 0);
			if (stall > 0) begin
				@(negedge clk);
				rsp.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!(rsp.valid && rsp.ready));
		end
	end

	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (matrix_q.size() == 0) begin
				$display("%0t unexpected transfer: got %h", $time, rsp.data);
				errors++;
			end else begin
				want = matrix_q.pop_front();
				for (int i = 0; i < 12; i++)
					if (want[(11-i)*32 +: 32] !== rsp.data[(11-i)*32 +: 32]) begin
						$display("%0t field %0d: expected %h actual %h", $time, i,
							want[(11-i)*32 +: 32], rsp.data[(11-i)*32 +: 32]);
						errors++;
					end
			end
		end
	end

	initial begin
		int waited;
		errors = 0;
		idle_free = 1'b0;
		req.valid <= 1'b0;
		req.data <= '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_degenerate();
		test_random(936);
		@(negedge clk);
		req.valid <= 1'b0;
		waited = 0;
		while (matrix_q.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		if (matrix_q.size() != 0) begin
			$display("%0t %0d results never arrived", $time, matrix_q.size());
			errors++;
		end
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
